FILE: design/ciq_pkg.sv
`timescale 1ns / 1ps
// ciq_pkg: shared constants, codes and beat types of the idle-connection expiry queue
// no dependencies

package ciq_pkg;

   localparam int SLOTS     = 64;
   localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LINK_W    = $clog2(SLOTS + 1);
   localparam int CNT_W     = $clog2(SLOTS + 1);
   localparam int CONN_W    = 6;
   localparam int FUNC_W    = 2;
   localparam int TIME_W    = 32;
   localparam int TIMEOUT_W = 16;

   localparam logic [LINK_W-1:0]    NONE_LINK     = LINK_W'(SLOTS);
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(15);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ACTIVITY = 2'd0,
      FUNC_HANGUP   = 2'd1,
      FUNC_TICK     = 2'd2,
      FUNC_UNUSED   = 2'd3
   } func_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CONN_W-1:0] conn_index;
      logic              keep;
   } req_type;

   typedef struct packed {
      logic              expired_valid;
      logic [CONN_W-1:0] expired_conn;
      logic              last;
      logic              queue_empty;
   } rsp_type;

endpackage

FILE: design/connection_idle_expiry_queue_top.sv
`timescale 1ns / 1ps
// connection_idle_expiry_queue_top: idle-connection expiry queue with link tables in memory
// depends on ciq_pkg

// Connections sit in a doubly linked list ordered by last activity, kept by slot index in
// link and deadline tables with one write port and one registered read port each. One item
// is worked at a time under a small sequencer and one shared 32-bit adder. An activity reads
// the slot's links, unlinks the slot when it was already queued and appends it at the tail; a
// hangup reads and unlinks the slot, or goes straight to its result when it is not queued; a
// tick advances the time, pops each expired head and then delivers the expired beats. Each
// table step waits on a registered read. Expired slots are collected first and then streamed,
// so every beat of a tick carries the final queue_empty. The result register lets the next
// item be accepted while a result beat is still waiting. idle_timeout may be written at any
// time the block is idle; the csr port is always ready.

module connection_idle_expiry_queue_top
   import ciq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [TIMEOUT_W-1:0] csr_data
);

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_LINK_RD  = 11'b000_0000_0010,
      ST_UNLINK   = 11'b000_0000_0100,
      ST_APPEND_A = 11'b000_0000_1000,
      ST_APPEND_B = 11'b000_0001_0000,
      ST_TICK     = 11'b000_0010_0000,
      ST_POP_RD   = 11'b000_0100_0000,
      ST_POP_CMP  = 11'b000_1000_0000,
      ST_DRAIN_RD = 11'b001_0000_0000,
      ST_DRAIN_OUT= 11'b010_0000_0000,
      ST_RESULT   = 11'b100_0000_0000
   } state_type;

   // tables
   logic [LINK_W-1:0] next_link_mem [SLOTS];
   logic [LINK_W-1:0] prev_link_mem [SLOTS];
   logic [TIME_W-1:0] deadline_mem  [SLOTS];
   logic [SLOT_W-1:0] rbuf_mem      [SLOTS];

   state_type          state_ff, state_in;
   req_type            item_ff, item_in;
   logic [SLOTS-1:0]   linked_ff, linked_in;
   logic [LINK_W-1:0]  head_ff, head_in;
   logic [LINK_W-1:0]  tail_ff, tail_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [LINK_W-1:0]  nl_rd_ff, pl_rd_ff;
   logic [TIME_W-1:0]  dl_rd_ff;
   logic [SLOT_W-1:0]  rbuf_rd_ff;

   logic               rd_en;
   logic [SLOT_W-1:0]  rd_addr;
   logic               nl_we, pl_we, dl_we, rbuf_we;
   logic [SLOT_W-1:0]  nl_waddr, pl_waddr, dl_waddr, rbuf_waddr;
   logic [LINK_W-1:0]  nl_wdata, pl_wdata;
   logic [SLOT_W-1:0]  rbuf_wdata;

   logic [TIME_W-1:0]  add_b, add_sum;
   logic [SLOT_W-1:0]  slot, req_slot, head_slot, tail_slot;
   logic               req_in_range, head_ok, tail_ok, p_ok, n_ok, out_free, drain_last;

   assign slot      = item_ff.conn_index[SLOT_W-1:0];
   assign req_slot  = req_data.conn_index[SLOT_W-1:0];
   assign head_slot = head_ff[SLOT_W-1:0];
   assign tail_slot = tail_ff[SLOT_W-1:0];
   assign req_in_range = (32'(req_data.conn_index) < SLOTS);
   assign head_ok   = (head_ff < NONE_LINK);
   assign tail_ok   = (tail_ff < NONE_LINK);
   assign p_ok      = (pl_rd_ff < NONE_LINK);
   assign n_ok      = (nl_rd_ff < NONE_LINK);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign drain_last = ((ptr_ff + CNT_W'(1)) == cnt_ff);

   // shared adder: tick step or activity deadline
   always_comb begin
      if (state_ff == ST_TICK) begin
         add_b = TIME_W'(1);
      end else if (item_ff.keep) begin
         add_b = TIME_W'(timeout_ff);
      end else begin
         add_b = '0;
      end
   end
   assign add_sum = now_ff + add_b;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      linked_in    = linked_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      now_in       = now_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      timeout_in   = csr_valid ? csr_data : timeout_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = slot;
      nl_we = 1'b0; nl_waddr = slot; nl_wdata = NONE_LINK;
      pl_we = 1'b0; pl_waddr = slot; pl_wdata = NONE_LINK;
      dl_we = 1'b0; dl_waddr = slot;
      rbuf_we = 1'b0; rbuf_waddr = cnt_ff[SLOT_W-1:0]; rbuf_wdata = head_slot;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               case (func_type'(req_data.func))
                  FUNC_ACTIVITY: state_in = req_in_range ? ST_LINK_RD : ST_RESULT;
                  FUNC_HANGUP: begin
                     state_in = (req_in_range && linked_ff[req_slot]) ? ST_LINK_RD : ST_RESULT;
                  end
                  FUNC_TICK: state_in = ST_TICK;
                  default: state_in = ST_RESULT;
               endcase
            end
         end
         ST_LINK_RD: begin
            rd_en = 1'b1;
            if (func_type'(item_ff.func) == FUNC_ACTIVITY) begin
               dl_we = 1'b1;
            end
            state_in = linked_ff[slot] ? ST_UNLINK : ST_APPEND_A;
         end
         ST_UNLINK: begin
            if (p_ok) begin
               nl_we    = 1'b1;
               nl_waddr = pl_rd_ff[SLOT_W-1:0];
               nl_wdata = nl_rd_ff;
            end else begin
               head_in = nl_rd_ff;
            end
            if (n_ok) begin
               pl_we    = 1'b1;
               pl_waddr = nl_rd_ff[SLOT_W-1:0];
               pl_wdata = pl_rd_ff;
            end else begin
               tail_in = pl_rd_ff;
            end
            linked_in[slot] = 1'b0;
            state_in = (func_type'(item_ff.func) == FUNC_ACTIVITY) ? ST_APPEND_A : ST_RESULT;
         end
         ST_APPEND_A: begin
            pl_we    = 1'b1;
            pl_wdata = tail_ff;
            nl_we    = 1'b1;
            nl_wdata = NONE_LINK;
            linked_in[slot] = 1'b1;
            state_in = ST_APPEND_B;
         end
         ST_APPEND_B: begin
            if (tail_ok) begin
               nl_we    = 1'b1;
               nl_waddr = tail_slot;
               nl_wdata = LINK_W'(slot);
            end else begin
               head_in = LINK_W'(slot);
            end
            tail_in  = LINK_W'(slot);
            state_in = ST_RESULT;
         end
         ST_TICK: begin
            now_in   = add_sum;
            cnt_in   = '0;
            state_in = ST_POP_RD;
         end
         ST_POP_RD: begin
            rd_addr = head_slot;
            if (!head_ok || cnt_ff == CNT_W'(SLOTS)) begin
               if (!head_ok) begin
                  now_in = '0;
               end
               ptr_in   = '0;
               state_in = (cnt_ff == '0) ? ST_RESULT : ST_DRAIN_RD;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_POP_CMP;
            end
         end
         ST_POP_CMP: begin
            if (dl_rd_ff > now_ff) begin
               ptr_in   = '0;
               state_in = (cnt_ff == '0) ? ST_RESULT : ST_DRAIN_RD;
            end else begin
               // head pops: its successor becomes head
               head_in = nl_rd_ff;
               if (n_ok) begin
                  pl_we    = 1'b1;
                  pl_waddr = nl_rd_ff[SLOT_W-1:0];
                  pl_wdata = NONE_LINK;
               end else begin
                  tail_in = NONE_LINK;
               end
               linked_in[head_slot] = 1'b0;
               rbuf_we  = 1'b1;
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = ST_POP_RD;
            end
         end
         ST_DRAIN_RD: begin
            state_in = ST_DRAIN_OUT;
         end
         ST_DRAIN_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.expired_valid = 1'b1;
               rsp_data_in.expired_conn  = CONN_W'(rbuf_rd_ff);
               rsp_data_in.last          = drain_last;
               rsp_data_in.queue_empty   = !head_ok;
               ptr_in   = ptr_ff + CNT_W'(1);
               state_in = drain_last ? ST_IDLE : ST_DRAIN_RD;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.expired_valid = 1'b0;
               rsp_data_in.expired_conn  = '0;
               rsp_data_in.last          = 1'b1;
               rsp_data_in.queue_empty   = !head_ok;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         linked_ff    <= '0;
         head_ff      <= NONE_LINK;
         tail_ff      <= NONE_LINK;
         now_ff       <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         cnt_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         linked_ff    <= linked_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         now_ff       <= now_in;
         timeout_ff   <= timeout_in;
         cnt_ff       <= cnt_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   // table ports: one write and one registered read each
   always_ff @(posedge clock) begin
      if (nl_we) begin
         next_link_mem[nl_waddr] <= nl_wdata;
      end
      if (rd_en) begin
         nl_rd_ff <= next_link_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (pl_we) begin
         prev_link_mem[pl_waddr] <= pl_wdata;
      end
      if (rd_en) begin
         pl_rd_ff <= prev_link_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (dl_we) begin
         deadline_mem[dl_waddr] <= add_sum;
      end
      if (rd_en) begin
         dl_rd_ff <= deadline_mem[rd_addr];
      end
   end

   // expired slots of the current tick, streamed out once the walk ends
   always_ff @(posedge clock) begin
      if (rbuf_we) begin
         rbuf_mem[rbuf_waddr] <= rbuf_wdata;
      end
      if (state_ff == ST_DRAIN_RD) begin
         rbuf_rd_ff <= rbuf_mem[ptr_ff[SLOT_W-1:0]];
      end
   end

`ifndef SYNTHESIS
   a_head_tail_agree: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((head_ff == NONE_LINK) == (tail_ff == NONE_LINK)))
      else $error("head and tail disagree on queue emptiness");

   a_linked_matches_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((linked_ff == '0) == (head_ff == NONE_LINK)))
      else $error("linked slots disagree with queue head");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= CNT_W'(SLOTS)))
      else $error("expired count beyond slot count");

   a_drain_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN_OUT) |-> (ptr_ff < cnt_ff))
      else $error("drain pointer past collected expiries");
`endif

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for connection_idle_expiry_queue_top with its own queue model
// depends on ciq_pkg and connection_idle_expiry_queue_top

module tb_top;
   import ciq_pkg::*;

   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_ITEMS   = 22;

   localparam rsp_type DONE_BUSY  = '{expired_valid: 1'b0, expired_conn: '0, last: 1'b1,
                                      queue_empty: 1'b0};
   localparam rsp_type DONE_EMPTY = '{expired_valid: 1'b0, expired_conn: '0, last: 1'b1,
                                      queue_empty: 1'b1};

   typedef struct {
      func_type          func;
      logic [CONN_W-1:0] conn;
      logic              keep;
      bit                typed;
      rsp_type           want;
   } plan_row_type;

   // untyped rows are checked against the queue model
   plan_row_type opening_plan [20] = '{
      '{FUNC_TICK,     6'd0,  1'b0, 1'b1, DONE_EMPTY},
      '{FUNC_ACTIVITY, 6'd0,  1'b1, 1'b1, DONE_BUSY},
      '{FUNC_ACTIVITY, 6'd63, 1'b0, 1'b1, DONE_BUSY},
      '{FUNC_TICK,     6'd0,  1'b0, 1'b0, DONE_BUSY},
      '{FUNC_ACTIVITY, 6'd0,  1'b1, 1'b1, DONE_BUSY},
      '{FUNC_TICK,     6'd0,  1'b0, 1'b0, DONE_BUSY},
      '{FUNC_HANGUP,   6'd5,  1'b0, 1'b1, DONE_BUSY},
      '{FUNC_UNUSED,   6'd63, 1'b1, 1'b1, DONE_BUSY},
      '{FUNC_HANGUP,   6'd0,  1'b0, 1'b1, DONE_EMPTY},
      '{FUNC_HANGUP,   6'd0,  1'b0, 1'b1, DONE_EMPTY},
      '{FUNC_ACTIVITY, 6'd1,  1'b0, 1'b1, DONE_BUSY},
      '{FUNC_ACTIVITY, 6'd2,  1'b0, 1'b1, DONE_BUSY},
      '{FUNC_ACTIVITY, 6'd42, 1'b1, 1'b1, DONE_BUSY},
      '{FUNC_ACTIVITY, 6'd21, 1'b0, 1'b1, DONE_BUSY},
      '{FUNC_ACTIVITY, 6'd1,  1'b1, 1'b1, DONE_BUSY},
      '{FUNC_TICK,     6'd0,  1'b0, 1'b0, DONE_BUSY},
      '{FUNC_HANGUP,   6'd42, 1'b0, 1'b1, DONE_BUSY},
      '{FUNC_TICK,     6'd0,  1'b0, 1'b0, DONE_BUSY},
      '{FUNC_HANGUP,   6'd1,  1'b0, 1'b1, DONE_EMPTY},
      '{FUNC_TICK,     6'd0,  1'b0, 1'b1, DONE_EMPTY}
   };

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [TIMEOUT_W-1:0] csr_data  = '0;

   // typed expectation travels with the request beat
   bit      req_typed = 1'b0;
   rsp_type req_want  = DONE_BUSY;

   bit calm = 1'b0;
   int error_count = 0;

   // queue model state
   logic [LINK_W-1:0]    link_next [SLOTS];
   logic [LINK_W-1:0]    link_prev [SLOTS];
   logic [TIME_W-1:0]    due_tick  [SLOTS];
   bit                   queued    [SLOTS];
   logic [LINK_W-1:0]    oldest_conn   = NONE_LINK;
   logic [LINK_W-1:0]    newest_conn   = NONE_LINK;
   logic [TIME_W-1:0]    model_now     = '0;
   logic [TIMEOUT_W-1:0] model_timeout = TIMEOUT_RESET;

   rsp_type pending_beats [$];

   connection_idle_expiry_queue_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void detach_conn(input logic [SLOT_W-1:0] s);
      logic [LINK_W-1:0] p;
      logic [LINK_W-1:0] n;
      p = link_prev[s];
      n = link_next[s];
      if (p == NONE_LINK) oldest_conn = n;
      else link_next[p[SLOT_W-1:0]] = n;
      if (n == NONE_LINK) newest_conn = p;
      else link_prev[n[SLOT_W-1:0]] = p;
      queued[s] = 1'b0;
   endfunction

   function automatic void append_conn(input logic [SLOT_W-1:0] s);
      link_prev[s] = newest_conn;
      link_next[s] = NONE_LINK;
      if (newest_conn == NONE_LINK) oldest_conn = LINK_W'(s);
      else link_next[newest_conn[SLOT_W-1:0]] = LINK_W'(s);
      newest_conn = LINK_W'(s);
      queued[s] = 1'b1;
   endfunction

   function automatic void advance_expiry_model(input req_type r);
      rsp_type           beats [$];
      rsp_type           b;
      logic [SLOT_W-1:0] s;
      s = r.conn_index[SLOT_W-1:0];
      case (r.func)
         FUNC_ACTIVITY: begin
            due_tick[s] = model_now + (r.keep ? TIME_W'(model_timeout) : TIME_W'(0));
            if (queued[s]) detach_conn(s);
            append_conn(s);
         end
         FUNC_HANGUP: begin
            if (queued[s]) detach_conn(s);
         end
         FUNC_TICK: begin
            model_now = model_now + TIME_W'(1);
            // plain unsigned compare, wrapped deadlines are not corrected
            while (oldest_conn != NONE_LINK &&
                   due_tick[oldest_conn[SLOT_W-1:0]] <= model_now) begin
               b = DONE_BUSY;
               b.expired_valid = 1'b1;
               b.expired_conn = oldest_conn[CONN_W-1:0];
               b.last = 1'b0;
               detach_conn(oldest_conn[SLOT_W-1:0]);
               beats.push_back(b);
            end
            if (oldest_conn == NONE_LINK) model_now = '0;
         end
         default: ;
      endcase
      if (beats.size() == 0) beats.push_back(DONE_BUSY);
      else beats[beats.size() - 1].last = 1'b1;
      foreach (beats[i]) begin
         beats[i].queue_empty = (oldest_conn == NONE_LINK);
         pending_beats.push_back(beats[i]);
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s: got %0d expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   task automatic check_beat(input rsp_type got);
      rsp_type want;
      if (pending_beats.size() == 0) begin
         report_mismatch("unexpected result beat", int'(got), 0);
         return;
      end
      want = pending_beats.pop_front();
      if (got.expired_valid !== want.expired_valid)
         report_mismatch("expired_valid", int'(got.expired_valid), int'(want.expired_valid));
      if (got.expired_conn !== want.expired_conn)
         report_mismatch("expired_conn", int'(got.expired_conn), int'(want.expired_conn));
      if (got.last !== want.last)
         report_mismatch("last", int'(got.last), int'(want.last));
      if (got.queue_empty !== want.queue_empty)
         report_mismatch("queue_empty", int'(got.queue_empty), int'(want.queue_empty));
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_beat(rsp_data);
         if (csr_valid && csr_ready) model_timeout = csr_data;
         if (req_valid && req_ready) begin
            advance_expiry_model(req_data);
            // typed rows always give a single beat
            if (req_typed) begin
               void'(pending_beats.pop_back());
               pending_beats.push_back(req_want);
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 34);
   end

   function automatic req_type make_req(input func_type f, input logic [CONN_W-1:0] c,
                                        input logic k);
      req_type r;
      r.func = f;
      r.conn_index = c;
      r.keep = k;
      return r;
   endfunction

   function automatic logic [CONN_W-1:0] pick_conn();
      // a small working set so connections get moved and hung up while queued
      if ($urandom_range(0, 99) < 60) return CONN_W'($urandom_range(0, 7));
      return CONN_W'($urandom_range(0, 63));
   endfunction

   task automatic send_req(input req_type r, input bit typed, input rsp_type want);
      while (!calm && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      req_typed <= typed;
      req_want  <= want;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_beats.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned       n;
      int unsigned       pick;
      int unsigned       sent;
      int unsigned       cfg_val;
      logic [SLOT_W-1:0] j;
      logic [CONN_W-1:0] order [SLOTS];
      logic [CONN_W-1:0] swap_conn;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_plan[i])
         send_req(make_req(opening_plan[i].func, opening_plan[i].conn, opening_plan[i].keep),
                  opening_plan[i].typed, opening_plan[i].want);

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: cfg_val = 0;
            1: cfg_val = 2;
            2: cfg_val = 65535;
            3: cfg_val = $urandom_range(3, 20);
            default: cfg_val = 1;
         endcase
         write_timeout(TIMEOUT_W'(cfg_val));
         calm = (ph == 3);

         if (ph == 0) begin
            for (int i = 0; i < SLOTS; i++) order[i] = CONN_W'(i);
            for (int i = SLOTS - 1; i > 0; i--) begin
               j = SLOT_W'($urandom_range(0, i));
               swap_conn = order[i];
               order[i] = order[j];
               order[j] = swap_conn;
            end
            foreach (order[i])
               send_req(make_req(FUNC_ACTIVITY, order[i], 1'($urandom_range(0, 1))),
                        1'b0, DONE_BUSY);
            // zero timeout: the whole table is due on this tick
            send_req(make_req(FUNC_TICK, '0, 1'b0), 1'b0, DONE_BUSY);
         end

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               // session: some activity, maybe a hangup, then 1 to timeout plus 2 ticks, capped at 14
               n = $urandom_range(1, 6);
               repeat (n) begin
                  send_req(make_req(FUNC_ACTIVITY, pick_conn(), 1'($urandom_range(0, 1))),
                           1'b0, DONE_BUSY);
                  sent++;
               end
               if ($urandom_range(0, 3) == 0) begin
                  send_req(make_req(FUNC_HANGUP, pick_conn(), 1'($urandom_range(0, 1))),
                           1'b0, DONE_BUSY);
                  sent++;
               end
               n = $urandom_range(1, (cfg_val > 12) ? 14 : cfg_val + 2);
               repeat (n) begin
                  send_req(make_req(FUNC_TICK, CONN_W'($urandom_range(0, 63)),
                                    1'($urandom_range(0, 1))), 1'b0, DONE_BUSY);
                  sent++;
               end
            end else begin
               send_req(make_req(func_type'($urandom_range(0, 3)),
                                 CONN_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1))),
                        1'b0, DONE_BUSY);
               sent++;
            end
         end
      end

      calm = 1'b0;
      wait_drained();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
